// File: design/fifo_with_batch_dequeue_sum_core_defines.svh
// Assertion macros for the batch-dequeue FIFO core.
`ifndef FIFO_WITH_BATCH_DEQUEUE_SUM_CORE_DEFINES_SVH
`define FIFO_WITH_BATCH_DEQUEUE_SUM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define FBDS_ASSERT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("fbds assertion failed");
// next-cycle implication, disabled in reset
`define FBDS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("fbds assertion failed");
`else
`define FBDS_ASSERT(lbl, pre, post)
`define FBDS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: design/fbds_pkg.sv
// Package: widths, codes, state type and control structs of the batch-dequeue FIFO.
package fbds_pkg;

  localparam int DEPTH_DEFAULT = 256;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 9;
  localparam int OCC_W         = 9;
  localparam int STATUS_W      = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_FULL   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAIN,
    S_TAIL,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic push;
    logic pop;
  } ptr_ctl_t;

  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctl_t;

endpackage

// File: design/fbds_if.sv
// Channel interfaces: command words in, result words out.
interface fbds_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     kind;
  logic signed [fbds_pkg::VALUE_W-1:0]      value;
  logic        [fbds_pkg::COUNT_W-1:0]      count;

  modport source (output valid, output kind, output value, output count, input ready);
  modport sink   (input valid, input kind, input value, input count, output ready);
endinterface

interface fbds_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [fbds_pkg::STATUS_W-1:0]     status;
  logic signed [fbds_pkg::VALUE_W-1:0]      sum;
  logic        [fbds_pkg::OCC_W-1:0]        occupancy;

  modport source (output valid, output status, output sum, output occupancy, input ready);
  modport sink   (input valid, input status, input sum, input occupancy, output ready);
endinterface

// File: design/fbds_ram.sv
// Entry store: one write port, one registered read port.
module fbds_ram #(
  parameter int DEPTH = fbds_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              we,
  input  logic [AW-1:0]                     waddr,
  input  logic [fbds_pkg::VALUE_W-1:0]      wdata,
  input  logic                              re,
  input  logic [AW-1:0]                     raddr,
  output logic [fbds_pkg::VALUE_W-1:0]      rdata
);

  logic [fbds_pkg::VALUE_W-1:0] mem [DEPTH];
  logic [fbds_pkg::VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/fbds_ptr.sv
// Ring pointers and occupancy counter.
module fbds_ptr #(
  parameter int DEPTH = fbds_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  fbds_pkg::ptr_ctl_t  ctl,
  output logic [AW-1:0]       wr_ptr,
  output logic [AW-1:0]       rd_ptr,
  output logic [CW-1:0]       count,
  output logic                full
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + AW'(1);
    end
    if (ctl.pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + AW'(1);
    end
    priority if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign wr_ptr = wr_ptr_r;
  assign rd_ptr = rd_ptr_r;
  assign count  = count_r;
  assign full   = (count_r == CW'(DEPTH));

endmodule

// File: design/fbds_acc.sv
// Shared 32-bit wrapping accumulator for the batch sum.
module fbds_acc (
  input  logic                          clk,
  input  fbds_pkg::acc_ctl_t            ctl,
  input  logic [fbds_pkg::VALUE_W-1:0]  operand,
  output logic [fbds_pkg::VALUE_W-1:0]  acc
);

  logic [fbds_pkg::VALUE_W-1:0] acc_r, acc_nxt;

  always_comb begin
    priority if (ctl.clr) begin
      acc_nxt = '0;
    end else if (ctl.add) begin
      acc_nxt = acc_r + operand;  // wraps mod 2^32
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

// File: design/fifo_with_batch_dequeue_sum_core.sv
// Top level: FIFO of signed 32-bit words with batch dequeue and summing.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+---------------------------------------
//  in_ch   | in  | valid / ready | kind, value[31:0], count[8:0]
//  out_ch  | out | valid / ready | status[1:0], sum[31:0], occupancy[8:0]
//
// Sequence: an enqueue, a rejected dequeue or a dequeue of zero words gives its
//   result word in the cycle after acceptance. A dequeue of n words runs DRAIN,
//   where the single RAM read port drains one entry a cycle into the shared
//   adder, then TAIL for the registered read data, then DONE to hand off the sum.
// Stalls: the result sits in an output register; a new command is taken while
//   the last result waits only if that register is free or being emptied.
// Reset: rst_n, synchronous, clears pointers, count, FSM and output valid.
//   The entry store is not cleared; entries are read only after being written.
`include "fifo_with_batch_dequeue_sum_core_defines.svh"

module fifo_with_batch_dequeue_sum_core #(
  parameter int DEPTH = fbds_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  fbds_in_if.sink       in_ch,
  fbds_out_if.source    out_ch
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = (CW > fbds_pkg::COUNT_W) ? CW : fbds_pkg::COUNT_W;
  localparam int VW    = fbds_pkg::VALUE_W;
  localparam int NW    = fbds_pkg::COUNT_W;

  // ---------------- sequencer state ----------------
  fbds_pkg::fsm_t state_r, state_nxt;
  logic [NW-1:0]  rem_r, rem_nxt;     // words still to read
  logic           pend_r;             // read data valid this cycle

  // ---------------- output register ----------------
  logic                       out_valid_r, out_valid_nxt;
  fbds_pkg::status_t          out_status_r, out_status_nxt;
  logic [VW-1:0]              out_sum_r, out_sum_nxt;
  logic [fbds_pkg::OCC_W-1:0] out_occ_r, out_occ_nxt;

  // ---------------- datapath wiring ----------------
  fbds_pkg::ptr_ctl_t ptr_ctl;
  fbds_pkg::acc_ctl_t acc_ctl;
  logic [AW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      count;
  logic               full;
  logic [VW-1:0]      rdata;
  logic [VW-1:0]      acc;

  logic               in_fire;
  logic               is_enq;
  logic               slot_free;
  logic [CMP_W-1:0]   cnt_ext;
  logic [CMP_W-1:0]   req_ext;
  logic               deq_reject;
  logic               deq_start;     // accepted dequeue with 1..occupancy words
  logic               pop;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign is_enq    = (in_ch.kind == fbds_pkg::KIND_ENQ);
  assign slot_free = !out_valid_r || out_ch.ready;
  assign cnt_ext   = CMP_W'(count);
  assign req_ext   = CMP_W'(in_ch.count);
  assign deq_reject = !is_enq && (req_ext > cnt_ext);
  assign deq_start  = in_fire && !is_enq && !deq_reject && (in_ch.count != '0);
  assign pop        = (state_r == fbds_pkg::S_DRAIN);

  assign ptr_ctl.push = in_fire && is_enq && !full;
  assign ptr_ctl.pop  = pop;
  assign acc_ctl.clr  = deq_start;
  assign acc_ctl.add  = pend_r;

  fbds_ptr #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ptr (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ptr_ctl),
    .wr_ptr (wr_ptr),
    .rd_ptr (rd_ptr),
    .count  (count),
    .full   (full)
  );

  fbds_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ptr_ctl.push),
    .waddr (wr_ptr),
    .wdata (in_ch.value),
    .re    (pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  fbds_acc u_acc (
    .clk     (clk),
    .ctl     (acc_ctl),
    .operand (rdata),
    .acc     (acc)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fbds_pkg::S_IDLE: begin
        if (deq_start) begin
          state_nxt = fbds_pkg::S_DRAIN;
        end
      end
      fbds_pkg::S_DRAIN: begin
        if (rem_r == NW'(1)) begin
          state_nxt = fbds_pkg::S_TAIL;
        end
      end
      fbds_pkg::S_TAIL: begin
        state_nxt = fbds_pkg::S_DONE;
      end
      fbds_pkg::S_DONE: begin
        if (slot_free) begin
          state_nxt = fbds_pkg::S_IDLE;
        end
      end
      default: state_nxt = fbds_pkg::S_IDLE;
    endcase
  end

  // ---------------- outputs of the sequencer ----------------
  always_comb begin
    in_ch.ready    = (state_r == fbds_pkg::S_IDLE) && slot_free;
    rem_nxt        = rem_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_sum_nxt    = out_sum_r;
    out_occ_nxt    = out_occ_r;
    unique case (state_r)
      fbds_pkg::S_IDLE: begin
        if (deq_start) begin
          rem_nxt = in_ch.count;
        end else if (in_fire) begin
          // results without a drain: enqueue, full drop, reject, zero-word dequeue
          out_valid_nxt = 1'b1;
          out_sum_nxt   = '0;
          out_occ_nxt   = cnt_ext[fbds_pkg::OCC_W-1:0];
          priority if (is_enq && full) begin
            out_status_nxt = fbds_pkg::STAT_FULL;
          end else if (is_enq) begin
            out_status_nxt = fbds_pkg::STAT_OK;
            out_occ_nxt    = fbds_pkg::OCC_W'(cnt_ext + CMP_W'(1));
          end else if (deq_reject) begin
            out_status_nxt = fbds_pkg::STAT_REJECT;
          end else begin
            out_status_nxt = fbds_pkg::STAT_OK;
          end
        end
      end
      fbds_pkg::S_DRAIN: begin
        rem_nxt = rem_r - NW'(1);
      end
      fbds_pkg::S_TAIL: begin
        rem_nxt = rem_r;
      end
      fbds_pkg::S_DONE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fbds_pkg::STAT_OK;
          out_sum_nxt    = acc;
          out_occ_nxt    = cnt_ext[fbds_pkg::OCC_W-1:0];
        end
      end
      default: rem_nxt = rem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fbds_pkg::S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pop;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_sum_r    <= out_sum_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.sum       = out_sum_r;
  assign out_ch.occupancy = out_occ_r;

  // ---------------- assertions ----------------
  `FBDS_ASSERT(a_count_max, 1'b1, count <= CW'(DEPTH))
  `FBDS_ASSERT(a_drain_rem, state_r == fbds_pkg::S_DRAIN, rem_r != '0)
  `FBDS_ASSERT(a_pend_state, pend_r, state_r == fbds_pkg::S_DRAIN || state_r == fbds_pkg::S_TAIL)
  `FBDS_ASSERT_NEXT(a_full_flag, in_fire && is_enq && full, out_valid_r && out_status_r == fbds_pkg::STAT_FULL)

endmodule
